// File: sv/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared types, codes and defaults for the bounded deque engine.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Default ring depth, in entries.
  localparam int unsigned DEFAULT_DEPTH = 128;

  // Fixed field widths.
  localparam int unsigned CNT_W = 8;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned REQ_W = 3;
  localparam int unsigned STAT_W = 3;

  // Request codes. The two codes above push by parity are invalid.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_RIGHT = 3'd0,
    REQ_PUSH_LEFT  = 3'd1,
    REQ_POP_LEFT   = 3'd2,
    REQ_POP_RIGHT  = 3'd3,
    REQ_QUERY      = 3'd4,
    REQ_PUSH_PAR   = 3'd5
  } req_code_t;

  // Response status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_NOSETUP = 3'd3,
    STAT_BADREQ  = 3'd4
  } status_t;

  // Request word.
  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] value;
  } req_word_t;

  // Response word.
  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] popped_value;
    logic [CNT_W-1:0]        count;
  } rsp_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted request word
    logic exec;    // execute the captured request
    logic cfg_we;  // write the capacity register
  } dp_cmd_t;

endpackage

// File: sv/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded deque controller
// Three-state sequencer: accept a request, execute it, hold the response
// until the receiver takes it.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  output bdq_pkg::dp_cmd_t cmd
);
  import bdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!rsp_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Handshake outputs and datapath commands.
  assign req_stall  = (state != S_IDLE);
  assign rsp_valid  = (state == S_RESP);
  assign cfg_ready  = (state == S_IDLE);
  assign cmd.load   = (state == S_IDLE) && req_valid;
  assign cmd.exec   = (state == S_EXEC);
  assign cmd.cfg_we = cfg_valid && (state == S_IDLE);

endmodule

// File: sv/bdq_datapath.sv
// ----------------------------------------------------------------------------
// Bounded deque datapath
// Ring store, left index, element count and capacity register, with the
// request decode and the response register.
// ----------------------------------------------------------------------------
module bdq_datapath #(
  parameter int unsigned DEPTH = bdq_pkg::DEFAULT_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bdq_pkg::dp_cmd_t          cmd,
  input  bdq_pkg::req_word_t        req,
  input  logic [bdq_pkg::CNT_W-1:0] cfg_data,
  output bdq_pkg::rsp_word_t        rsp
);
  import bdq_pkg::*;

  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SUM_W   = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam int unsigned CAP_LIM = (DEPTH > 255) ? 255 : DEPTH;

  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] CAP_LIM_C = CNT_W'(CAP_LIM);

  // Ring store.
  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data;

  // Architectural state.
  logic [CNT_W-1:0] capacity;
  logic [IDX_W-1:0] left_index;
  logic [CNT_W-1:0] elem_count;

  // Captured request.
  logic [REQ_W-1:0] req_type;
  logic [VAL_W-1:0] value;

  // Response register.
  status_t          resp_status;
  logic [CNT_W-1:0] resp_count;
  logic             pop_ok;

  // Execute-cycle decode.
  logic [CNT_W-1:0] eff_cap;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] cnt_m1;
  logic [SUM_W-1:0] sum_right;
  logic [SUM_W-1:0] sum_last;
  logic [SUM_W-1:0] wrap_right;
  logic [SUM_W-1:0] wrap_last;
  logic [IDX_W-1:0] left_dec;
  logic [IDX_W-1:0] left_inc;
  logic             go_right;
  logic             go_left;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  status_t          status_next;
  logic [IDX_W-1:0] left_index_next;
  logic [CNT_W-1:0] elem_count_next;
  logic             pop_ok_next;

  // Ring arithmetic: every sum stays below twice the depth.
  always_comb begin
    eff_cap    = (capacity > CAP_LIM_C) ? CAP_LIM_C : capacity;
    full       = (elem_count >= eff_cap);
    empty      = (elem_count == '0);
    cnt_m1     = elem_count - CNT_W'(1);
    sum_right  = SUM_W'(left_index) + SUM_W'(elem_count);
    sum_last   = SUM_W'(left_index) + SUM_W'(cnt_m1);
    wrap_right = (sum_right >= DEPTH_S) ? sum_right - DEPTH_S : sum_right;
    wrap_last  = (sum_last >= DEPTH_S) ? sum_last - DEPTH_S : sum_last;
    left_dec   = (left_index == '0) ? IDX_LAST : left_index - IDX_W'(1);
    left_inc   = (left_index == IDX_LAST) ? '0 : left_index + IDX_W'(1);
    go_right   = (req_type == REQ_PUSH_RIGHT) ||
                 ((req_type == REQ_PUSH_PAR) && !value[0]);
    go_left    = (req_type == REQ_PUSH_LEFT) ||
                 ((req_type == REQ_PUSH_PAR) && value[0]);
  end

  // Request decode.
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = wrap_right[IDX_W-1:0];
    mem_re          = 1'b0;
    mem_raddr       = left_index;
    status_next     = STAT_OK;
    left_index_next = left_index;
    elem_count_next = elem_count;
    pop_ok_next     = 1'b0;
    if (req_type > REQ_W'(REQ_PUSH_PAR)) begin
      status_next = STAT_BADREQ;
    end else if (capacity == '0) begin
      status_next = STAT_NOSETUP;
    end else if (go_right || go_left) begin
      if (full) begin
        status_next = STAT_FULL;
      end else begin
        mem_we          = 1'b1;
        elem_count_next = elem_count + CNT_W'(1);
        if (go_left) begin
          mem_waddr       = left_dec;
          left_index_next = left_dec;
        end
      end
    end else if ((req_type == REQ_POP_LEFT) || (req_type == REQ_POP_RIGHT)) begin
      if (empty) begin
        status_next = STAT_EMPTY;
      end else begin
        mem_re          = 1'b1;
        pop_ok_next     = 1'b1;
        elem_count_next = cnt_m1;
        if (req_type == REQ_POP_LEFT) begin
          left_index_next = left_inc;
        end else begin
          mem_raddr = wrap_last[IDX_W-1:0];
        end
      end
    end
  end

  // Ring store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[mem_waddr] <= value;
    end
    if (cmd.exec && mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Request capture and response register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type <= req.req_type;
      value    <= req.value;
    end
    if (cmd.exec) begin
      resp_status <= status_next;
      resp_count  <= elem_count_next;
      pop_ok      <= pop_ok_next;
    end
  end

  // Deque state; a capacity write empties the deque.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= '0;
      left_index <= '0;
      elem_count <= '0;
    end else if (cmd.cfg_we) begin
      capacity   <= cfg_data;
      left_index <= '0;
      elem_count <= '0;
    end else if (cmd.exec) begin
      left_index <= left_index_next;
      elem_count <= elem_count_next;
    end
  end

  assign rsp.status       = resp_status;
  assign rsp.popped_value = pop_ok ? rd_data : '0;
  assign rsp.count        = resp_count;

endmodule

// File: sv/bounded_deque_engine_top.sv
// ----------------------------------------------------------------------------
// Bounded deque engine
// A bounded double-ended queue of signed 32-bit values in a ring store.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive as a word on req with req_valid; the engine raises
// req_stall while it works on one. Each request yields exactly one response
// word on rsp with rsp_valid, held steady while rsp_stall is high.
// A request is taken in the accept state and executed in the next cycle
// (one ring store access and the pointer update); its response is valid
// from the cycle after that, held in the response state.
// The capacity register is written through cfg_valid / cfg_ready / cfg_data
// while the engine is idle; any write empties the deque. Capacity 0 means the
// deque is not set up and every request fails.
// Reset clears the capacity to 0 and empties the deque; the ring store is not
// cleared, since only held elements are ever read.
// ----------------------------------------------------------------------------
module bounded_deque_engine_top #(
  parameter int unsigned DEPTH = bdq_pkg::DEFAULT_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  bdq_pkg::req_word_t        req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output bdq_pkg::rsp_word_t        rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bdq_pkg::CNT_W-1:0] cfg_data
);
  import bdq_pkg::*;

  dp_cmd_t cmd;

  // Sequencer.
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // Ring store and deque state.
  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_data (cfg_data),
    .rsp      (rsp)
  );

  // An accepted request has its response word ready after the execute state.
  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |-> ##2 rsp_valid)
    else $error("response not ready two cycles after request");

  // No new request is taken while a response waits.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request accepted while response pending");

  // Only a successful pop returns a nonzero value.
  a_pop_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != STAT_OK)) |-> (rsp.popped_value == '0))
    else $error("failed request returned a value");

  // The element count never passes the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp.count) <= DEPTH))
    else $error("element count beyond depth");

endmodule

// File: tb/bounded_deque_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque engine testbench
// Drives request words through the deque engine under random gaps and
// response stalls, and predicts every response word from a local copy of
// the ring, its left position, its element count and the capacity. A short
// table of directed requests covers not set up, bad codes, full, empty,
// parity pushes and ring wrap. Random phases with many capacities follow,
// steering the deque from empty to full and back again.
// ----------------------------------------------------------------------------
module bounded_deque_engine_top_tb;
  import bdq_pkg::*;

  localparam int unsigned RING_DEPTH = DEFAULT_DEPTH;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam logic [REQ_W-1:0] REQ_BAD_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_BAD_HI = 3'd7;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // One directed step: either a capacity write or a request word, the
  // latter with an optional typed-in response.
  typedef struct {
    bit                      is_cfg;
    logic [CNT_W-1:0]        cap;
    logic [REQ_W-1:0]        code;
    logic signed [VAL_W-1:0] value;
    bit                      typed;
    rsp_word_t               want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_word_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_word_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  // Local copy of the deque state.
  logic signed [VAL_W-1:0] ring_copy [RING_DEPTH];
  int unsigned left_pos;
  int unsigned held;
  logic [CNT_W-1:0] cap_reg;

  rsp_word_t awaited_rsp [$];
  plan_row_t plan [$];
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned calm_left = 0;
  bit note_on = 1'b0;
  rsp_word_t note_word = '0;

  bounded_deque_engine_top #(.DEPTH(RING_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Run limit, far above the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Applies one request to the local deque copy and returns its response.
  function automatic rsp_word_t deque_outcome(input logic [REQ_W-1:0] code,
                                              input logic signed [VAL_W-1:0] v);
    rsp_word_t r;
    int unsigned bound;
    logic [REQ_W-1:0] op;
    r.status = STAT_OK;
    r.popped_value = '0;
    bound = (cap_reg > RING_DEPTH) ? RING_DEPTH : cap_reg;
    // A parity push is a left push for odd values, a right push otherwise.
    op = code;
    if (code == REQ_PUSH_PAR)
      op = v[0] ? REQ_PUSH_LEFT : REQ_PUSH_RIGHT;
    if (code > REQ_PUSH_PAR) begin
      r.status = STAT_BADREQ;
    end else if (cap_reg == 0) begin
      r.status = STAT_NOSETUP;
    end else begin
      case (op)
        REQ_PUSH_RIGHT, REQ_PUSH_LEFT: begin
          if (held >= bound) begin
            r.status = STAT_FULL;
          end else if (op == REQ_PUSH_RIGHT) begin
            ring_copy[(left_pos + held) % RING_DEPTH] = v;
            held++;
          end else begin
            left_pos = (left_pos + RING_DEPTH - 1) % RING_DEPTH;
            ring_copy[left_pos] = v;
            held++;
          end
        end
        REQ_POP_LEFT: begin
          if (held == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            r.popped_value = ring_copy[left_pos];
            left_pos = (left_pos + 1) % RING_DEPTH;
            held--;
          end
        end
        REQ_POP_RIGHT: begin
          if (held == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            r.popped_value = ring_copy[(left_pos + held - 1) % RING_DEPTH];
            held--;
          end
        end
        default: begin
        end
      endcase
    end
    r.count = CNT_W'(held);
    return r;
  endfunction

  // Compares one response word with its expectation, field by field.
  task automatic check_word(input rsp_word_t want, input rsp_word_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fault_count++;
    end
    if (got.popped_value !== want.popped_value) begin
      $error("popped_value: expected %0d, got %0d", want.popped_value, got.popped_value);
      fault_count++;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, got.count);
      fault_count++;
    end
  endtask

  // Tracks capacity writes and accepted requests, and checks responses.
  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      left_pos = 0;
      held = 0;
      cap_reg = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_data;
        left_pos = 0;
        held = 0;
      end
      if (req_valid && !req_stall) begin
        want = deque_outcome(req.req_type, req.value);
        if (note_on)
          want = note_word;
        awaited_rsp.push_back(want);
      end
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          $error("response word with no request waiting: status %0d", rsp.status);
          fault_count++;
        end else begin
          check_word(awaited_rsp.pop_front(), rsp);
        end
      end
    end
  end

  // Response side: calm stretches, and stalls that are mostly short.
  initial begin
    int unsigned run;
    int unsigned pick;
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        run = $urandom_range(20, 60);
        repeat (run) begin
          @(negedge clk);
          rsp_stall <= 1'b0;
        end
      end else begin
        run = $urandom_range(0, 3);
        repeat (run) begin
          @(negedge clk);
          rsp_stall <= 1'b0;
        end
        run = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        repeat (run) begin
          @(negedge clk);
          rsp_stall <= 1'b1;
        end
      end
    end
  end

  // Idle cycles before the next request word.
  function automatic int unsigned sender_gap();
    int unsigned pick;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Presents one request word and returns at the falling edge after it
  // was taken. Entered at a falling edge.
  task automatic send_req(input logic [REQ_W-1:0] code, input logic signed [VAL_W-1:0] v,
                          input bit typed, input rsp_word_t want);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{req_type: code, value: v};
    note_on = typed;
    note_word = want;
    do @(posedge clk); while (!(req_valid && !req_stall));
    @(negedge clk);
  endtask

  // Waits until the engine is idle, then writes the capacity register.
  task automatic set_capacity(input logic [CNT_W-1:0] cap);
    req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_cfg(input logic [CNT_W-1:0] cap);
    plan_row_t row;
    row = '{is_cfg: 1'b1, cap: cap, code: '0, value: '0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_req(input logic [REQ_W-1:0] code,
                                  input logic signed [VAL_W-1:0] v);
    plan_row_t row;
    row = '{is_cfg: 1'b0, cap: '0, code: code, value: v, typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_chk(input logic [REQ_W-1:0] code, input logic signed [VAL_W-1:0] v,
                                  input status_t st, input logic signed [VAL_W-1:0] popped,
                                  input logic [CNT_W-1:0] cnt);
    plan_row_t row;
    row = '{is_cfg: 1'b0, cap: '0, code: code, value: v, typed: 1'b1,
            want: '{status: st, popped_value: popped, count: cnt}};
    plan.push_back(row);
  endfunction

  // A random value, with the extremes now and then.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // A random request code, leaning toward pushes while filling and toward
  // pops while draining.
  function automatic logic [REQ_W-1:0] pick_code(input bit filling);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (filling) begin
      if (pick < 27) return REQ_PUSH_RIGHT;
      if (pick < 54) return REQ_PUSH_LEFT;
      if (pick < 80) return REQ_PUSH_PAR;
      if (pick < 88) return REQ_POP_LEFT;
      if (pick < 94) return REQ_POP_RIGHT;
    end else begin
      if (pick < 38) return REQ_POP_LEFT;
      if (pick < 76) return REQ_POP_RIGHT;
      if (pick < 80) return REQ_PUSH_RIGHT;
      if (pick < 84) return REQ_PUSH_LEFT;
      if (pick < 94) return REQ_PUSH_PAR;
    end
    if (pick < 97) return REQ_QUERY;
    return (pick < 99) ? REQ_BAD_LO : REQ_BAD_HI;
  endfunction

  initial begin
    logic [CNT_W-1:0] phase_cap [8];
    int unsigned phase_len [8];
    int unsigned bound;
    bit filling;

    // Directed steps. Before any capacity write the deque is not set up.
    add_chk(REQ_QUERY, '0, STAT_NOSETUP, '0, 8'd0);
    add_chk(REQ_PUSH_RIGHT, VAL_MAX, STAT_NOSETUP, '0, 8'd0);
    add_chk(REQ_BAD_LO, '0, STAT_BADREQ, '0, 8'd0);
    add_chk(REQ_BAD_HI, -1, STAT_BADREQ, '0, 8'd0);
    // Capacity two: fill from both ends, hit full, drain, hit empty.
    add_cfg(8'd2);
    add_chk(REQ_PUSH_RIGHT, VAL_MAX, STAT_OK, '0, 8'd1);
    add_chk(REQ_PUSH_LEFT, VAL_MIN, STAT_OK, '0, 8'd2);
    add_chk(REQ_PUSH_PAR, 32'sd4, STAT_FULL, '0, 8'd2);
    add_chk(REQ_QUERY, '0, STAT_OK, '0, 8'd2);
    add_chk(REQ_POP_RIGHT, '0, STAT_OK, VAL_MAX, 8'd1);
    add_chk(REQ_POP_LEFT, '0, STAT_OK, VAL_MIN, 8'd0);
    add_chk(REQ_POP_LEFT, '0, STAT_EMPTY, '0, 8'd0);
    add_chk(REQ_POP_RIGHT, '0, STAT_EMPTY, '0, 8'd0);
    add_chk(REQ_BAD_HI, '0, STAT_BADREQ, '0, 8'd0);
    // Parity pushes: a negative odd value goes left, an even one right.
    add_req(REQ_PUSH_PAR, -1);
    add_req(REQ_PUSH_PAR, -2);
    add_req(REQ_POP_LEFT, '0);
    add_req(REQ_POP_RIGHT, '0);
    // Capacity above the ring depth; a left push from position zero wraps.
    add_cfg(8'd255);
    add_req(REQ_PUSH_LEFT, 32'sd11);
    add_req(REQ_PUSH_RIGHT, 32'sd22);
    add_req(REQ_POP_RIGHT, '0);
    add_req(REQ_POP_RIGHT, '0);
    add_chk(REQ_POP_LEFT, '0, STAT_EMPTY, '0, 8'd0);
    // Capacity one, then back to not set up.
    add_cfg(8'd1);
    add_chk(REQ_PUSH_RIGHT, '0, STAT_OK, '0, 8'd1);
    add_chk(REQ_PUSH_LEFT, 32'sd5, STAT_FULL, '0, 8'd1);
    add_chk(REQ_PUSH_PAR, -7, STAT_FULL, '0, 8'd1);
    add_cfg(8'd0);
    add_chk(REQ_QUERY, '0, STAT_NOSETUP, '0, 8'd0);

    // Random phases: capacity and number of request words in each.
    phase_cap = '{8'd128, 8'd255, 8'd1, 8'd0, 8'd3, 8'($urandom_range(4, 40)),
                  8'($urandom_range(41, 127)), 8'($urandom_range(129, 254))};
    phase_len = '{240, 180, 40, 20, 60, 80, 120, 60};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        set_capacity(plan[i].cap);
      else
        send_req(plan[i].code, plan[i].value, plan[i].typed, plan[i].want);
    end

    foreach (phase_cap[p]) begin
      set_capacity(phase_cap[p]);
      filling = 1'b1;
      repeat (phase_len[p]) begin
        // Turn around at full and at empty, now and then lingering there.
        bound = (cap_reg > RING_DEPTH) ? RING_DEPTH : cap_reg;
        if (filling && held >= bound && $urandom_range(0, 3) == 0)
          filling = 1'b0;
        else if (!filling && held == 0 && $urandom_range(0, 3) == 0)
          filling = 1'b1;
        send_req(pick_code(filling), pick_value(), 1'b0, '0);
      end
    end

    // Drain, then allow the response latency before the verdict.
    req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk);
    repeat (2 * DRAIN_CYCLES) @(negedge clk);
    if (awaited_rsp.size() != 0) begin
      $error("%0d expected response words never arrived", awaited_rsp.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
